>>> rtl/core/salc_pkg.sv
// shared types, constants and register codes for the set-associative lru cache model
`default_nettype none
package salc_pkg;

	// default geometry limits
	localparam int MAX_SETS_DEF = 64;
	localparam int MAX_WAYS_DEF = 8;

	// field widths
	localparam int ADDR_W     = 32;
	localparam int TAG_W      = 32;
	localparam int POS_W      = 3;
	localparam int CNT_W      = 32;
	localparam int CYC_W      = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIT_COST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS_COST   = 3'd4;

	// register reset values
	localparam logic [3:0]  RST_OFFSET_BITS = 4'd5;
	localparam logic [2:0]  RST_SET_BITS    = 3'd1;
	localparam logic [3:0]  RST_WAYS_IN_USE = 4'd8;
	localparam logic [7:0]  RST_HIT_COST    = 8'd4;
	localparam logic [15:0] RST_MISS_COST   = 16'd836;

	// configuration seen by front and back
	typedef struct packed {
		logic [3:0]  offset_bits;
		logic [2:0]  set_bits;
		logic [3:0]  ways_in_use;
		logic [7:0]  hit_cost;
		logic [15:0] miss_cost;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/salc_front.sv
// front end: accepts addresses and splits them into set row and tag
`default_nettype none
module salc_front #(
	parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
	parameter int ROW_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  wire salc_pkg::cfg_t              cfg,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire [salc_pkg::ADDR_W-1:0]       address,
	input  wire                              q_full,
	output logic                             q_push,
	output logic [ROW_W-1:0]                 row,
	output logic [salc_pkg::TAG_W-1:0]       tag
);
	import salc_pkg::*;

	// largest set bits value that fits the row store
	localparam int MAX_SB_I = $clog2(MAX_SETS + 1) - 1;
	localparam logic [3:0] MAX_SB = 4'((MAX_SB_I > 7) ? 7 : MAX_SB_I);

	logic [2:0]        sb;
	logic [4:0]        shift;
	logic [ADDR_W-1:0] set_mask;
	logic [ADDR_W-1:0] set_full;

	// request handshake into the queue
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// clamp set bits to the row store
	assign sb = ({1'b0, cfg.set_bits} > MAX_SB) ? MAX_SB[2:0] : cfg.set_bits;

	// address split
	assign set_mask = (ADDR_W'(1) << sb) - ADDR_W'(1);
	assign set_full = (address >> cfg.offset_bits) & set_mask;
	assign row      = set_full[ROW_W-1:0];
	assign shift    = {1'b0, cfg.offset_bits} + {2'b00, sb};
	assign tag      = TAG_W'(address >> shift);

endmodule
`default_nettype wire

>>> rtl/core/salc_queue.sv
// short request queue between front end and back end
`default_nettype none
module salc_queue #(
	parameter int WIDTH = 38
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  push_data,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	import salc_pkg::*;

	logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/salc_back.sv
// back end: tag row read, lru update and write-back, totals and result register
`default_nettype none
module salc_back #(
	parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
	parameter int ROW_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire salc_pkg::cfg_t              cfg,
	input  wire                              q_empty,
	input  wire [ROW_W-1:0]                  q_row,
	input  wire [salc_pkg::TAG_W-1:0]        q_tag,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             hit,
	output logic [salc_pkg::POS_W-1:0]       hit_position,
	output logic [salc_pkg::CNT_W-1:0]       access_total,
	output logic [salc_pkg::CNT_W-1:0]       miss_total,
	output logic [salc_pkg::CYC_W-1:0]       cycle_total
);
	import salc_pkg::*;

	localparam int ENT_W  = TAG_W + 1;
	localparam int ROW_DW = MAX_WAYS * ENT_W;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int PIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	localparam logic ST_FETCH  = 1'b0;
	localparam logic ST_UPDATE = 1'b1;

	logic                state_q;
	logic [ROW_W-1:0]    row_q;
	logic [TAG_W-1:0]    tag_q;
	logic [ROW_DW-1:0]   mem_q [MAX_SETS];
	logic [ROW_DW-1:0]   rd_data_q;
	logic                rd_rowvld_q;
	logic [MAX_SETS-1:0] row_vld_q;
	logic                out_valid_q;
	logic                hit_q;
	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    acc_q;
	logic [CNT_W-1:0]    miss_q;
	logic [CYC_W-1:0]    cyc_q;

	logic                out_free;
	logic                rd_en;
	logic                wr_en;
	logic [WCNT_W-1:0]   ways;
	logic [ROW_DW-1:0]   old_row;
	logic [ROW_DW-1:0]   new_row;
	logic [MAX_WAYS-1:0] match;
	logic                found;
	logic [PIDX_W-1:0]   pos;
	logic [PIDX_W-1:0]   last;
	logic [PIDX_W+2:0]   pos_wide;
	logic [15:0]         cost;
	logic [CYC_W:0]      cyc_sum;

	// sequencing: fetch reads the row, update writes it back
	assign out_free = !out_valid_q || !out_stall;
	assign rd_en    = (state_q == ST_FETCH) && !q_empty;
	assign q_pop    = rd_en;
	assign wr_en    = (state_q == ST_UPDATE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FETCH;
		end else begin
			unique case (state_q)
				ST_FETCH: begin
					if (rd_en) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (wr_en) begin
						state_q <= ST_FETCH;
					end
				end
			endcase
		end
	end

	// request held for the update cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_q <= q_row;
			tag_q <= q_tag;
		end
	end

	// tag row memory, one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q   <= mem_q[q_row];
			rd_rowvld_q <= row_vld_q[q_row];
		end
		if (wr_en) begin
			mem_q[row_q] <= new_row;
		end
	end

	// rows never written read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[row_q] <= 1'b1;
		end
	end

	assign old_row = rd_rowvld_q ? rd_data_q : '0;

	// ways in use, clamped
	always_comb begin
		if (cfg.ways_in_use == 4'd0) begin
			ways = WCNT_W'(1);
		end else if (int'(cfg.ways_in_use) > MAX_WAYS) begin
			ways = WCNT_W'(MAX_WAYS);
		end else begin
			ways = WCNT_W'(cfg.ways_in_use);
		end
	end

	// tag compare over the ways in use
	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			match[i] = (WCNT_W'(i) < ways) && old_row[i*ENT_W + TAG_W]
				&& (old_row[i*ENT_W +: TAG_W] == tag_q);
		end
	end

	// first matching way
	always_comb begin
		pos = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				pos = PIDX_W'(i);
			end
		end
	end

	assign found = |match;
	assign last  = found ? pos : PIDX_W'(ways - WCNT_W'(1));

	// recency shift, new tag enters the front
	always_comb begin
		new_row = old_row;
		new_row[0 +: ENT_W] = {1'b1, tag_q};
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (PIDX_W'(i) <= last) begin
				new_row[i*ENT_W +: ENT_W] = old_row[(i-1)*ENT_W +: ENT_W];
			end
		end
	end

	// cost and saturating cycle sum
	assign cost     = found ? {8'd0, cfg.hit_cost} : cfg.miss_cost;
	assign cyc_sum  = {1'b0, cyc_q} + (CYC_W+1)'(cost);
	assign pos_wide = {3'b000, pos};

	// totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			miss_q      <= '0;
			cyc_q       <= '0;
		end else begin
			if (wr_en) begin
				out_valid_q <= 1'b1;
				if (acc_q != '1) begin
					acc_q <= acc_q + CNT_W'(1);
				end
				if (!found && (miss_q != '1)) begin
					miss_q <= miss_q + CNT_W'(1);
				end
				cyc_q <= cyc_sum[CYC_W] ? '1 : cyc_sum[CYC_W-1:0];
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hit_q <= found;
			pos_q <= found ? pos_wide[POS_W-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign hit_position = pos_q;
	assign access_total = acc_q;
	assign miss_total   = miss_q;
	assign cycle_total  = cyc_q;

endmodule
`default_nettype wire

>>> rtl/core/set_assoc_lru_cache_model.sv
// top level of the set-associative lru cache model
//
// Each request on the input channel (in_valid, in_stall, address) is one byte
// address. It is split into set and tag, queued, then looked up in the set's
// recency-ordered tag row; one result per request leaves on the output channel
// (out_valid, out_stall, hit, hit_position and the running totals).
// An accepted request is queued, its tag row is read in the fetch state and its
// result registered in the update state; a new request is popped only after
// the row is written back via the single read/write port pair of the row memory.
// A two-entry queue decouples the front end from the back end, so requests are
// still taken while a result waits in the output register.
// Stalling the output holds the result and all totals steady; the queue then
// fills and in_stall rises.
// Reset clears the totals, the queue and the per-row written flags; a row not
// written since reset reads as all ways empty, so no clearing pass is needed.
// Configuration writes (cfg_we, cfg_index, cfg_data) belong to idle periods.
`default_nettype none
module set_assoc_lru_cache_model #(
	parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire [salc_pkg::ADDR_W-1:0]         address,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic                               hit,
	output logic [salc_pkg::POS_W-1:0]         hit_position,
	output logic [salc_pkg::CNT_W-1:0]         access_total,
	output logic [salc_pkg::CNT_W-1:0]         miss_total,
	output logic [salc_pkg::CYC_W-1:0]         cycle_total
);
	import salc_pkg::*;

	localparam int ROW_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int QW    = ROW_W + TAG_W;

	cfg_t             cfg_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	logic [ROW_W-1:0] f_row;
	logic [TAG_W-1:0] f_tag;
	logic [QW-1:0]    q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_bits <= RST_OFFSET_BITS;
			cfg_q.set_bits    <= RST_SET_BITS;
			cfg_q.ways_in_use <= RST_WAYS_IN_USE;
			cfg_q.hit_cost    <= RST_HIT_COST;
			cfg_q.miss_cost   <= RST_MISS_COST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS: cfg_q.offset_bits <= cfg_data[3:0];
				CFG_SET_BITS:    cfg_q.set_bits    <= cfg_data[2:0];
				CFG_WAYS_IN_USE: cfg_q.ways_in_use <= cfg_data[3:0];
				CFG_HIT_COST:    cfg_q.hit_cost    <= cfg_data[7:0];
				CFG_MISS_COST:   cfg_q.miss_cost   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// address split
	salc_front #(
		.MAX_SETS (MAX_SETS),
		.ROW_W    (ROW_W)
	) u_front (
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.address  (address),
		.q_full   (q_full),
		.q_push   (q_push),
		.row      (f_row),
		.tag      (f_tag)
	);

	// request queue
	salc_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_row, f_tag}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_head),
		.empty     (q_empty)
	);

	// lookup, lru update and totals
	salc_back #(
		.MAX_SETS (MAX_SETS),
		.MAX_WAYS (MAX_WAYS),
		.ROW_W    (ROW_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_row        (q_head[QW-1:TAG_W]),
		.q_tag        (q_head[TAG_W-1:0]),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.hit_position (hit_position),
		.access_total (access_total),
		.miss_total   (miss_total),
		.cycle_total  (cycle_total)
	);

	// checks
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	a_miss_le_access: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (miss_total <= access_total))
		else $error("miss total above access total");

	a_result_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (access_total != '0))
		else $error("result shown with no access counted");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (hit_position == '0))
		else $error("miss with nonzero recency position");

endmodule
`default_nettype wire
